[hw/rtl/ftw_pkg.sv]
`default_nettype none

package ftw_pkg;

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [0:0] REG_SLOT = 1'b0;
	localparam logic [8:0] SLOT_RESET = 9'h1FF;

	localparam logic [2:0] OP_TRANSLATE = 3'd0;
	localparam logic [2:0] OP_PROBE     = 3'd1;
	localparam logic [2:0] OP_MAP       = 3'd2;
	localparam logic [2:0] OP_UNMAP     = 3'd3;
	localparam logic [2:0] OP_SET       = 3'd4;
	localparam logic [2:0] OP_CLEAR     = 3'd5;
	localparam logic [2:0] OP_RESPONSE  = 3'd6;

	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_NONE  = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_MISORDER = 3'd5;

	localparam logic [1:0] LVL_4 = 2'd0;
	localparam logic [1:0] LVL_3 = 2'd1;
	localparam logic [1:0] LVL_2 = 2'd2;
	localparam logic [1:0] LVL_1 = 2'd3;

	localparam int unsigned BIT_PRESENT = 0;
	localparam int unsigned BIT_PS      = 7;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [47:0] vaddr;
		logic [51:0] frame_addr;
		logic [63:0] flag_bits;
		logic [63:0] read_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  req_kind;
		logic [63:0] mem_addr;
		logic [63:0] write_data;
		logic        done_res;
		logic [2:0]  status;
		logic [51:0] paddr;
		logic        flush;
	} out_item_t;

	typedef struct packed {
		logic        busy;
		logic [2:0]  op;
		logic [1:0]  level;
		logic [47:0] vaddr;
		logic [51:0] frame;
		logic [63:0] flags;
	} walk_state_t;

	function automatic logic [63:0] entry_addr(input logic [1:0] lv, input logic [47:0] va,
			input logic [8:0] r);
		logic [8:0] i4;
		logic [8:0] i3;
		logic [8:0] i2;
		logic [8:0] i1;
		logic [26:0] mid;
		logic [8:0] ix;
		i4 = va[47:39];
		i3 = va[38:30];
		i2 = va[29:21];
		i1 = va[20:12];
		case (lv)
			LVL_4: begin
				mid = {r, r, r};
				ix = i4;
			end
			LVL_3: begin
				mid = {r, r, i4};
				ix = i3;
			end
			LVL_2: begin
				mid = {r, i4, i3};
				ix = i2;
			end
			default: begin
				mid = {i4, i3, i2};
				ix = i1;
			end
		endcase
		return {{16{r[8]}}, r, mid, ix, 3'b000};
	endfunction

endpackage

`default_nettype wire

[hw/rtl/ftw_if.sv]
`default_nettype none

interface ftw_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [47:0] vaddr;
	logic [51:0] frame_addr;
	logic [63:0] flag_bits;
	logic [63:0] read_data;

	modport source(output valid, cmd, vaddr, frame_addr, flag_bits, read_data, input ready);
	modport sink(input valid, cmd, vaddr, frame_addr, flag_bits, read_data, output ready);
endinterface

interface ftw_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_kind;
	logic [63:0] mem_addr;
	logic [63:0] write_data;
	logic        done_res;
	logic [2:0]  status;
	logic [51:0] paddr;
	logic        flush;

	modport source(output valid, req_kind, mem_addr, write_data, done_res, status, paddr,
		flush, input ready);
	modport sink(input valid, req_kind, mem_addr, write_data, done_res, status, paddr,
		flush, output ready);
endinterface

`default_nettype wire

[hw/rtl/ftw_apb.sv]
`default_nettype none

module ftw_apb (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [ftw_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [ftw_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [ftw_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready,
	output logic      [8:0]                     slot
);

	logic [8:0] slot_q;
	logic       hit;

	assign hit = (paddr[ftw_pkg::APB_ADDR_W-1] == ftw_pkg::REG_SLOT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= ftw_pkg::SLOT_RESET;
		end else if (psel && penable && pwrite && hit) begin
			slot_q <= pwdata[8:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = hit ? {{(ftw_pkg::APB_DATA_W-9){1'b0}}, slot_q} : '0;
	assign slot = slot_q;

endmodule

`default_nettype wire

[hw/rtl/ftw_step.sv]
`default_nettype none

module ftw_step (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 advance,
	input  wire ftw_pkg::in_item_t    item,
	input  wire logic [8:0]           slot,
	output ftw_pkg::out_item_t        res,
	output logic                      busy
);

	ftw_pkg::walk_state_t state_q;
	ftw_pkg::walk_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.busy  <= 1'b0;
			state_q.op    <= ftw_pkg::OP_TRANSLATE;
			state_q.level <= ftw_pkg::LVL_4;
			state_q.vaddr <= '0;
			state_q.frame <= '0;
			state_q.flags <= '0;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	always_comb begin
		logic [63:0] e;
		logic [47:0] va;
		logic [1:0]  lv;
		logic [63:0] leaf_addr;
		e = item.read_data;
		va = state_q.vaddr;
		lv = state_q.level;
		leaf_addr = ftw_pkg::entry_addr(ftw_pkg::LVL_1, va, slot);
		state_d = state_q;
		res.req_kind = ftw_pkg::REQ_NONE;
		res.mem_addr = '0;
		res.write_data = '0;
		res.done_res = 1'b1;
		res.status = ftw_pkg::ST_MISORDER;
		res.paddr = '0;
		res.flush = 1'b0;
		if (item.cmd != ftw_pkg::OP_RESPONSE) begin
			if (item.cmd <= ftw_pkg::OP_CLEAR && !state_q.busy) begin
				state_d.busy = 1'b1;
				state_d.op = item.cmd;
				state_d.level = ftw_pkg::LVL_4;
				state_d.vaddr = item.vaddr;
				state_d.frame = item.frame_addr;
				state_d.flags = item.flag_bits;
				res.req_kind = ftw_pkg::REQ_READ;
				res.mem_addr = ftw_pkg::entry_addr(ftw_pkg::LVL_4, item.vaddr, slot);
				res.done_res = 1'b0;
				res.status = ftw_pkg::ST_OK;
			end
		end else if (state_q.busy) begin
			res.status = ftw_pkg::ST_OK;
			if (!e[ftw_pkg::BIT_PRESENT]) begin
				state_d.busy = 1'b0;
				res.status = 3'(3'd4 - {1'b0, lv});
			end else if (state_q.op == ftw_pkg::OP_TRANSLATE && lv == ftw_pkg::LVL_3 &&
					e[ftw_pkg::BIT_PS]) begin
				state_d.busy = 1'b0;
				res.paddr = {e[51:30], va[29:0]};
			end else if (state_q.op == ftw_pkg::OP_TRANSLATE && lv == ftw_pkg::LVL_2 &&
					e[ftw_pkg::BIT_PS]) begin
				state_d.busy = 1'b0;
				res.paddr = {e[51:21], va[20:0]};
			end else if (state_q.op == ftw_pkg::OP_MAP && lv == ftw_pkg::LVL_2) begin
				state_d.busy = 1'b0;
				res.req_kind = ftw_pkg::REQ_WRITE;
				res.mem_addr = leaf_addr;
				res.write_data = {12'b0, state_q.frame[51:12], 12'b0} | state_q.flags;
				res.flush = 1'b1;
			end else if (lv != ftw_pkg::LVL_1) begin
				state_d.level = lv + 2'd1;
				res.req_kind = ftw_pkg::REQ_READ;
				res.mem_addr = ftw_pkg::entry_addr(lv + 2'd1, va, slot);
				res.done_res = 1'b0;
			end else begin
				state_d.busy = 1'b0;
				case (state_q.op)
					ftw_pkg::OP_TRANSLATE: begin
						res.paddr = {e[51:12], va[11:0]};
					end
					ftw_pkg::OP_UNMAP: begin
						res.req_kind = ftw_pkg::REQ_WRITE;
						res.mem_addr = leaf_addr;
						res.paddr = {e[51:12], 12'b0};
						res.flush = 1'b1;
					end
					ftw_pkg::OP_SET: begin
						res.req_kind = ftw_pkg::REQ_WRITE;
						res.mem_addr = leaf_addr;
						res.write_data = e | state_q.flags;
						res.flush = 1'b1;
					end
					ftw_pkg::OP_CLEAR: begin
						res.req_kind = ftw_pkg::REQ_WRITE;
						res.mem_addr = leaf_addr;
						res.write_data = e & ~state_q.flags;
						res.flush = 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign busy = state_q.busy;

endmodule

`default_nettype wire

[hw/rtl/four_level_page_table_walker_top.sv]
// four-level page table walker through a recursive self-map slot
// item channel: a command (translate, probe, map, unmap, set, clear) or a read
//   response carrying the table entry asked for by the last read request
// result channel: one beat per item beat; a read request, a leaf write with
//   flush, or completion with status and translated address
// apb port: register 0 at byte address 0 holds the recursive slot (9 bits)
// path: each accepted item beat goes through the input register, then one
//   combinational walk step into the result register
// throughput: one item per cycle while results are taken, set by the single walk
//   step stage; the walk state updates as each item leaves the input register
// a response can only arrive after the matching read request has been taken,
//   so a walk of n levels costs n round trips through external memory
// reset: walker idle, slot 511, no beat held in either register
// stall: the result register holds its beat until taken; the input register
//   keeps accepting until it is full, then item ready drops
`default_nettype none

module four_level_page_table_walker_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	ftw_in_if.sink                              item,
	ftw_out_if.source                           result,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [ftw_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [ftw_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [ftw_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready
);

	ftw_pkg::in_item_t  item_s1;
	logic               valid_s1;
	ftw_pkg::out_item_t result_s2;
	logic               valid_s2;
	ftw_pkg::out_item_t step_res;
	logic               advance;
	logic               busy;
	logic [8:0]         slot;

	ftw_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.slot    (slot)
	);

	assign advance = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.cmd <= item.cmd;
			item_s1.vaddr <= item.vaddr;
			item_s1.frame_addr <= item.frame_addr;
			item_s1.flag_bits <= item.flag_bits;
			item_s1.read_data <= item.read_data;
		end
	end

	ftw_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.slot    (slot),
		.res     (step_res),
		.busy    (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= step_res;
		end
	end

	assign result.valid = valid_s2;
	assign result.req_kind = result_s2.req_kind;
	assign result.mem_addr = result_s2.mem_addr;
	assign result.write_data = result_s2.write_data;
	assign result.done_res = result_s2.done_res;
	assign result.status = result_s2.status;
	assign result.paddr = result_s2.paddr;
	assign result.flush = result_s2.flush;

`ifndef ASSERT_OFF
	a_read_keeps_busy: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_res.req_kind == ftw_pkg::REQ_READ |=> busy)
		else $error("walker idle after issuing a read request");

	a_done_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_res.done_res && step_res.status != ftw_pkg::ST_MISORDER |=> !busy)
		else $error("walker still busy after completing a command");

	a_write_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.req_kind == ftw_pkg::REQ_WRITE |->
		result_s2.flush && result_s2.done_res && result_s2.status == ftw_pkg::ST_OK)
		else $error("leaf write without flush or completion");

	a_slot_write: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[ftw_pkg::APB_ADDR_W-1] == ftw_pkg::REG_SLOT |=>
		slot == $past(pwdata[8:0]))
		else $error("recursive slot not updated by register write");
`endif

endmodule

`default_nettype wire
